### src/rti_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ray-triangle intersection package
// Shared widths, constants, types and helpers for the intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_W  = 21;
    localparam int NCOORD   = 3;
    localparam int VEC_W    = COORD_W * NCOORD;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int XPROD_W  = 2 * EDGE_W;
    localparam int XDIFF_W  = XPROD_W + 1;
    localparam int FRAC_SH  = 10;
    localparam int CROSS_W  = XDIFF_W - FRAC_SH;
    localparam int DPROD_W  = EDGE_W + CROSS_W;
    localparam int DOT_W    = 60;
    localparam int EPS_W    = 16;
    localparam int EPS_SH   = 4;
    localparam int DIST_W   = 32;
    localparam int BARY_W   = 16;
    localparam int T_SH     = 16;
    localparam int DIV_Q    = 32;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;

    localparam int NXT [NCOORD] = '{1, 2, 0};
    localparam int PRV [NCOORD] = '{2, 0, 1};

    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [XPROD_W-1:0] xprod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [DPROD_W-1:0] dprod_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic              sat;
        logic              ntpos;
        logic [DIST_W-1:0] maxd;
        logic [DOT_W-1:0]  a;
        logic [DOT_W-1:0]  t_r0;
        logic [DIV_Q-1:0]  t_low;
        logic [DOT_W-1:0]  u_r0;
        logic [DIV_Q-1:0]  u_low;
        logic [DOT_W-1:0]  v_r0;
        logic [DIV_Q-1:0]  v_low;
    } geom_res_t;

    typedef struct packed {
        logic              ok;
        logic              sat;
        logic              ntpos;
        logic [DIST_W-1:0] maxd;
    } side_t;

    function automatic edge_t coord(input logic [VEC_W-1:0] p, input int idx);
        logic signed [COORD_W-1:0] c;
        c = $signed(p[idx*COORD_W +: COORD_W]);
        return EDGE_W'(c);
    endfunction

endpackage
`default_nettype wire

### src/rti_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per register stage from a remainder below the
// divisor and a word of low numerator bits shifted in from the top.
// ----------------------------------------------------------------------------
module rti_div
    import rti_pkg::*;
#(
    parameter int WIDTH = DOT_W,
    parameter int QBITS = DIV_Q
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] d_in,
    input  wire logic [WIDTH-1:0] r_in,
    input  wire logic [QBITS-1:0] low_in,
    output logic      [QBITS-1:0] q_out
);

    logic [WIDTH-1:0] r_reg [QBITS];
    logic [WIDTH-1:0] d_reg [QBITS];
    logic [QBITS-1:0] l_reg [QBITS];
    logic [QBITS-1:0] q_reg [QBITS];

    logic [WIDTH-1:0] r_src [QBITS];
    logic [WIDTH-1:0] d_src [QBITS];
    logic [QBITS-1:0] l_src [QBITS];
    logic [QBITS-1:0] q_src [QBITS];

    genvar k;
    for (k = 0; k < QBITS; k++) begin : g_stage
        logic [WIDTH:0] r2;
        logic           ge;

        if (k == 0) begin : g_first
            assign r_src[k] = r_in;
            assign d_src[k] = d_in;
            assign l_src[k] = low_in;
            assign q_src[k] = '0;
        end else begin : g_rest
            assign r_src[k] = r_reg[k-1];
            assign d_src[k] = d_reg[k-1];
            assign l_src[k] = l_reg[k-1];
            assign q_src[k] = q_reg[k-1];
        end

        assign r2 = {r_src[k], l_src[k][QBITS-1]};
        assign ge = (r2 >= {1'b0, d_src[k]});

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k] <= ge ? WIDTH'(r2 - {1'b0, d_src[k]}) : r2[WIDTH-1:0];
                d_reg[k] <= d_src[k];
                l_reg[k] <= {l_src[k][QBITS-2:0], 1'b0};
                q_reg[k] <= {q_src[k][QBITS-2:0], ge};
            end
        end
    end

    assign q_out = q_reg[QBITS-1];

endmodule
`default_nettype wire

### src/rti_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Intersection geometry front end
// Six register stages: edges, cross products, floor to Q.10, dot products,
// sums, then sign fix, hit tests and divider setup.
// ----------------------------------------------------------------------------
module rti_geom
    import rti_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [VEC_W-1:0]  v0,
    input  wire logic [VEC_W-1:0]  v1,
    input  wire logic [VEC_W-1:0]  v2,
    input  wire logic [VEC_W-1:0]  org,
    input  wire logic [VEC_W-1:0]  dir,
    input  wire logic [DIST_W-1:0] max_dist,
    input  wire logic [EPS_W-1:0]  eps,
    output geom_res_t              res
);

    logic [4:0] vld_reg;
    logic [DIST_W-1:0] maxd_reg [5];

    edge_t  s1_e0_reg [NCOORD];
    edge_t  s1_e1_reg [NCOORD];
    edge_t  s1_s_reg  [NCOORD];
    edge_t  s1_d_reg  [NCOORD];

    edge_t  s2_e0_reg [NCOORD];
    edge_t  s2_e1_reg [NCOORD];
    edge_t  s2_s_reg  [NCOORD];
    edge_t  s2_d_reg  [NCOORD];
    xprod_t s2_hp_reg [NCOORD];
    xprod_t s2_hm_reg [NCOORD];
    xprod_t s2_qp_reg [NCOORD];
    xprod_t s2_qm_reg [NCOORD];

    logic signed [XDIFF_W-1:0] hdiff [NCOORD];
    logic signed [XDIFF_W-1:0] qdiff [NCOORD];

    edge_t  s3_e0_reg [NCOORD];
    edge_t  s3_e1_reg [NCOORD];
    edge_t  s3_s_reg  [NCOORD];
    edge_t  s3_d_reg  [NCOORD];
    cross_t s3_h_reg  [NCOORD];
    cross_t s3_q_reg  [NCOORD];

    dprod_t s4_pa_reg [NCOORD];
    dprod_t s4_pu_reg [NCOORD];
    dprod_t s4_pv_reg [NCOORD];
    dprod_t s4_pt_reg [NCOORD];

    dot_t s5_a_reg;
    dot_t s5_nu_reg;
    dot_t s5_nv_reg;
    dot_t s5_nt_reg;

    dot_t      aa;
    dot_t      nu;
    dot_t      nv;
    dot_t      nt;
    dot_t      eps20;
    dot_t      nt_hi;
    dot_t      nu_hi;
    dot_t      nv_hi;
    geom_res_t res_next;
    geom_res_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            res_reg.valid <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[3:0], in_valid};
            res_reg.valid <= vld_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            maxd_reg[0] <= max_dist;
            for (int j = 1; j < 5; j++) begin
                maxd_reg[j] <= maxd_reg[j-1];
            end
            for (int i = 0; i < NCOORD; i++) begin
                s1_e0_reg[i] <= coord(v1, i) - coord(v0, i);
                s1_e1_reg[i] <= coord(v2, i) - coord(v0, i);
                s1_s_reg[i]  <= coord(org, i) - coord(v0, i);
                s1_d_reg[i]  <= coord(dir, i);

                s2_e0_reg[i] <= s1_e0_reg[i];
                s2_e1_reg[i] <= s1_e1_reg[i];
                s2_s_reg[i]  <= s1_s_reg[i];
                s2_d_reg[i]  <= s1_d_reg[i];
                s2_hp_reg[i] <= s1_d_reg[NXT[i]] * s1_e1_reg[PRV[i]];
                s2_hm_reg[i] <= s1_d_reg[PRV[i]] * s1_e1_reg[NXT[i]];
                s2_qp_reg[i] <= s1_s_reg[NXT[i]] * s1_e0_reg[PRV[i]];
                s2_qm_reg[i] <= s1_s_reg[PRV[i]] * s1_e0_reg[NXT[i]];

                s3_e0_reg[i] <= s2_e0_reg[i];
                s3_e1_reg[i] <= s2_e1_reg[i];
                s3_s_reg[i]  <= s2_s_reg[i];
                s3_d_reg[i]  <= s2_d_reg[i];
                s3_h_reg[i]  <= hdiff[i][XDIFF_W-1:FRAC_SH];
                s3_q_reg[i]  <= qdiff[i][XDIFF_W-1:FRAC_SH];

                s4_pa_reg[i] <= s3_e0_reg[i] * s3_h_reg[i];
                s4_pu_reg[i] <= s3_s_reg[i] * s3_h_reg[i];
                s4_pv_reg[i] <= s3_d_reg[i] * s3_q_reg[i];
                s4_pt_reg[i] <= s3_e1_reg[i] * s3_q_reg[i];
            end
            s5_a_reg  <= DOT_W'(s4_pa_reg[0]) + DOT_W'(s4_pa_reg[1]) + DOT_W'(s4_pa_reg[2]);
            s5_nu_reg <= DOT_W'(s4_pu_reg[0]) + DOT_W'(s4_pu_reg[1]) + DOT_W'(s4_pu_reg[2]);
            s5_nv_reg <= DOT_W'(s4_pv_reg[0]) + DOT_W'(s4_pv_reg[1]) + DOT_W'(s4_pv_reg[2]);
            s5_nt_reg <= DOT_W'(s4_pt_reg[0]) + DOT_W'(s4_pt_reg[1]) + DOT_W'(s4_pt_reg[2]);

            res_reg.ok    <= res_next.ok;
            res_reg.sat   <= res_next.sat;
            res_reg.ntpos <= res_next.ntpos;
            res_reg.maxd  <= res_next.maxd;
            res_reg.a     <= res_next.a;
            res_reg.t_r0  <= res_next.t_r0;
            res_reg.t_low <= res_next.t_low;
            res_reg.u_r0  <= res_next.u_r0;
            res_reg.u_low <= res_next.u_low;
            res_reg.v_r0  <= res_next.v_r0;
            res_reg.v_low <= res_next.v_low;
        end
    end

    always_comb begin
        for (int i = 0; i < NCOORD; i++) begin
            hdiff[i] = XDIFF_W'(s2_hp_reg[i]) - XDIFF_W'(s2_hm_reg[i]);
            qdiff[i] = XDIFF_W'(s2_qp_reg[i]) - XDIFF_W'(s2_qm_reg[i]);
        end
    end

    always_comb begin
        if (s5_a_reg[DOT_W-1]) begin
            aa = -s5_a_reg;
            nu = -s5_nu_reg;
            nv = -s5_nv_reg;
            nt = -s5_nt_reg;
        end else begin
            aa = s5_a_reg;
            nu = s5_nu_reg;
            nv = s5_nv_reg;
            nt = s5_nt_reg;
        end
        eps20 = $signed({{(DOT_W - EPS_W - EPS_SH){1'b0}}, eps, {EPS_SH{1'b0}}});
        nt_hi = nt >>> T_SH;
        nu_hi = nu >>> T_SH;
        nv_hi = nv >>> T_SH;

        res_next       = '0;
        res_next.valid = vld_reg[4];
        res_next.ok    = (aa > eps20) && (nu > 0) && (nu < aa) && (nv > 0)
                         && ((nu + nv) < aa);
        res_next.sat   = (nt_hi >= aa);
        res_next.ntpos = (nt > 0);
        res_next.maxd  = maxd_reg[4];
        res_next.a     = aa;
        res_next.t_r0  = nt_hi;
        res_next.t_low = {nt[T_SH-1:0], {(DIV_Q - T_SH){1'b0}}};
        res_next.u_r0  = nu_hi;
        res_next.u_low = {nu[T_SH-1:0], {(DIV_Q - T_SH){1'b0}}};
        res_next.v_r0  = nv_hi;
        res_next.v_low = {nv[T_SH-1:0], {(DIV_Q - T_SH){1'b0}}};
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### src/ray_triangle_intersect_core.sv
`default_nettype none
// Pipeline: an accepted item passes 6 geometry stages, 32 divider stages and
// 1 output register to its result. Throughput: one item per cycle unless the
// output stalls; the 32-stage bit-per-stage dividers set the depth. The whole
// pipeline holds while the output register is full and m_ready is low.
// Reset: synchronous active-low aresetn clears all valid bits and sets
// epsilon to 66.
// ----------------------------------------------------------------------------
// Ray-triangle intersection core
// Fixed-point Moller-Trumbore test with pipelined distance and barycentric
// division, one result item for every input item.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core
    import rti_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              epsilon_wr_en,
    input  wire logic [EPS_W-1:0]  epsilon_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [VEC_W-1:0]  s_vertex_zero,
    input  wire logic [VEC_W-1:0]  s_vertex_one,
    input  wire logic [VEC_W-1:0]  s_vertex_two,
    input  wire logic [VEC_W-1:0]  s_ray_origin,
    input  wire logic [VEC_W-1:0]  s_ray_direction,
    input  wire logic [DIST_W-1:0] s_max_distance,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_hit,
    output logic [DIST_W-1:0]      m_distance,
    output logic [BARY_W-1:0]      m_bary_u,
    output logic [BARY_W-1:0]      m_bary_v
);

    logic [EPS_W-1:0] eps_reg;
    logic             en;
    geom_res_t        geo;
    logic [DIV_Q-1:0] tq;
    logic [DIV_Q-1:0] uq;
    logic [DIV_Q-1:0] vq;

    logic [DIV_Q-1:0] vld_reg;
    side_t            side_reg [DIV_Q];

    logic [DIST_W-1:0] t_val;
    logic              hit_next;

    logic              m_valid_reg;
    logic              m_hit_reg;
    logic [DIST_W-1:0] m_distance_reg;
    logic [BARY_W-1:0] m_bary_u_reg;
    logic [BARY_W-1:0] m_bary_v_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (epsilon_wr_en) begin
            eps_reg <= epsilon_wr_data;
        end
    end

    rti_geom u_geom (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .v0       (s_vertex_zero),
        .v1       (s_vertex_one),
        .v2       (s_vertex_two),
        .org      (s_ray_origin),
        .dir      (s_ray_direction),
        .max_dist (s_max_distance),
        .eps      (eps_reg),
        .res      (geo)
    );

    rti_div #(.WIDTH(DOT_W), .QBITS(DIV_Q)) u_div_t (
        .aclk (aclk), .en (en), .d_in (geo.a), .r_in (geo.t_r0),
        .low_in (geo.t_low), .q_out (tq)
    );

    rti_div #(.WIDTH(DOT_W), .QBITS(DIV_Q)) u_div_u (
        .aclk (aclk), .en (en), .d_in (geo.a), .r_in (geo.u_r0),
        .low_in (geo.u_low), .q_out (uq)
    );

    rti_div #(.WIDTH(DOT_W), .QBITS(DIV_Q)) u_div_v (
        .aclk (aclk), .en (en), .d_in (geo.a), .r_in (geo.v_r0),
        .low_in (geo.v_low), .q_out (vq)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_Q-2:0], geo.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= '{ok: geo.ok, sat: geo.sat, ntpos: geo.ntpos, maxd: geo.maxd};
            for (int j = 1; j < DIV_Q; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_comb begin
        if (!side_reg[DIV_Q-1].ntpos) begin
            t_val = '0;
        end else if (side_reg[DIV_Q-1].sat) begin
            t_val = '1;
        end else begin
            t_val = tq;
        end
        hit_next = side_reg[DIV_Q-1].ok && (t_val > DIST_W'(eps_reg))
                   && (t_val < side_reg[DIV_Q-1].maxd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[DIV_Q-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_hit_reg      <= hit_next;
            m_distance_reg <= hit_next ? t_val : '0;
            m_bary_u_reg   <= hit_next ? uq[BARY_W-1:0] : '0;
            m_bary_v_reg   <= hit_next ? vq[BARY_W-1:0] : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_distance = m_distance_reg;
    assign m_bary_u   = m_bary_u_reg;
    assign m_bary_v   = m_bary_v_reg;

endmodule
`default_nettype wire

### bench/ray_triangle_intersect_core_test.sv
// ----------------------------------------------------------------------------
// Ray-triangle intersection core testbench
// Streams directed and random ray-triangle pairs through the core under
// several epsilon settings, with bursty input and a stalling receiver, and
// checks every result item against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_core_test;
    import rti_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 50;
    localparam longint UNIT       = 1024;

    typedef struct packed {
        logic [VEC_W-1:0]  v0;
        logic [VEC_W-1:0]  v1;
        logic [VEC_W-1:0]  v2;
        logic [VEC_W-1:0]  orig;
        logic [VEC_W-1:0]  dir;
        logic [DIST_W-1:0] maxd;
    } ray_pair_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic [BARY_W-1:0] bary_u;
        logic [BARY_W-1:0] bary_v;
    } hit_info_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              epsilon_wr_en = 1'b0;
    logic [EPS_W-1:0]  epsilon_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_hit;
    logic [DIST_W-1:0] m_distance;
    logic [BARY_W-1:0] m_bary_u;
    logic [BARY_W-1:0] m_bary_v;

    ray_pair_t   cur_pair = '0;
    ray_pair_t   pending_pairs[$];
    hit_info_t   expected_hits[$];
    logic [EPS_W-1:0] model_eps = EPS_RESET;
    logic        hold_sender = 1'b0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          cycle_count = 0;
    int          idle_cycles = 0;
    int          mismatches = 0;

    ray_triangle_intersect_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .epsilon_wr_en   (epsilon_wr_en),
        .epsilon_wr_data (epsilon_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_vertex_zero   (cur_pair.v0),
        .s_vertex_one    (cur_pair.v1),
        .s_vertex_two    (cur_pair.v2),
        .s_ray_origin    (cur_pair.orig),
        .s_ray_direction (cur_pair.dir),
        .s_max_distance  (cur_pair.maxd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_distance      (m_distance),
        .m_bary_u        (m_bary_u),
        .m_bary_v        (m_bary_v)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic longint unpack_coord(logic [VEC_W-1:0] p, int idx);
        logic signed [COORD_W-1:0] c;
        c = p[idx*COORD_W +: COORD_W];
        return longint'(c);
    endfunction

    function automatic logic [VEC_W-1:0] pack_vec(longint x, longint y, longint z);
        logic [COORD_W-1:0] cx, cy, cz;
        cx = x[COORD_W-1:0];
        cy = y[COORD_W-1:0];
        cz = z[COORD_W-1:0];
        return {cz, cy, cx};
    endfunction

    // Floor of n * 2^16 / d for n >= 0 and d > 0, saturated to 32 bits.
    function automatic logic [63:0] scaled_quotient(longint n, longint d);
        logic [127:0] quot;
        quot = (128'(n) << 16) / 128'(d);
        if (quot > 128'hFFFF_FFFF) begin
            return 64'hFFFF_FFFF;
        end
        return quot[63:0];
    endfunction

    function automatic hit_info_t predict_hit(ray_pair_t rp, logic [EPS_W-1:0] eps);
        longint p0[3], e0[3], e1[3], s[3], d[3], h[3], q[3];
        longint a, nu, nv, nt;
        logic [63:0] t;
        bit ok;
        hit_info_t r;
        for (int i = 0; i < 3; i++) begin
            p0[i] = unpack_coord(rp.v0, i);
            e0[i] = unpack_coord(rp.v1, i) - p0[i];
            e1[i] = unpack_coord(rp.v2, i) - p0[i];
            s[i]  = unpack_coord(rp.orig, i) - p0[i];
            d[i]  = unpack_coord(rp.dir, i);
        end
        h[0] = (d[1] * e1[2] - d[2] * e1[1]) >>> 10;
        h[1] = (d[2] * e1[0] - d[0] * e1[2]) >>> 10;
        h[2] = (d[0] * e1[1] - d[1] * e1[0]) >>> 10;
        q[0] = (s[1] * e0[2] - s[2] * e0[1]) >>> 10;
        q[1] = (s[2] * e0[0] - s[0] * e0[2]) >>> 10;
        q[2] = (s[0] * e0[1] - s[1] * e0[0]) >>> 10;
        a  = e0[0] * h[0] + e0[1] * h[1] + e0[2] * h[2];
        nu = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
        nv = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        nt = e1[0] * q[0] + e1[1] * q[1] + e1[2] * q[2];
        if (a < 0) begin
            a = -a;
            nu = -nu;
            nv = -nv;
            nt = -nt;
        end
        r = '0;
        ok = a > (longint'(eps) << EPS_SH);
        ok = ok && nu > 0 && nu < a && nv > 0 && nu + nv < a;
        if (ok) begin
            t = (nt > 0) ? scaled_quotient(nt, a) : 64'd0;
            ok = t > 64'(eps) && t < 64'(rp.maxd);
            if (ok) begin
                r.hit = 1'b1;
                r.distance = t[DIST_W-1:0];
                r.bary_u = BARY_W'(scaled_quotient(nu, a));
                r.bary_v = BARY_W'(scaled_quotient(nv, a));
            end
        end
        return r;
    endfunction

    function automatic longint rand_coord(int range_bits);
        longint span;
        span = longint'(1) << range_bits;
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [VEC_W-1:0] rand_vec();
        return VEC_W'({$urandom, $urandom});
    endfunction

    // Triangle with a ray aimed at a point near or inside it.
    function automatic ray_pair_t aimed_pair();
        ray_pair_t rp;
        longint v0[3], v1[3], v2[3], o[3], dir[3];
        longint bu, bv, tgt;
        int rb, k;
        rb = ($urandom_range(0, 3) == 0) ? 17 : 12;
        k = $urandom_range(0, 4);
        bu = $urandom_range(0, 255);
        bv = $urandom_range(0, 255);
        if ($urandom_range(0, 3) != 0 && bu + bv > 255) begin
            bu = 255 - bu;
            bv = 255 - bv;
        end
        for (int i = 0; i < 3; i++) begin
            v0[i] = rand_coord(rb);
            v1[i] = rand_coord(rb);
            v2[i] = rand_coord(rb);
            o[i]  = rand_coord(rb);
            tgt = v0[i] + ((bu * (v1[i] - v0[i]) + bv * (v2[i] - v0[i])) >>> 8);
            dir[i] = (tgt - o[i]) >>> k;
        end
        rp.v0 = pack_vec(v0[0], v0[1], v0[2]);
        rp.v1 = pack_vec(v1[0], v1[1], v1[2]);
        rp.v2 = pack_vec(v2[0], v2[1], v2[2]);
        rp.orig = pack_vec(o[0], o[1], o[2]);
        rp.dir = pack_vec(dir[0], dir[1], dir[2]);
        case ($urandom_range(0, 3))
            0: rp.maxd = 32'hFFFF_FFFF;
            1: rp.maxd = $urandom;
            2: rp.maxd = $urandom_range(0, 32'h0020_0000);
            default: rp.maxd = 32'(65536) << k;
        endcase
        return rp;
    endfunction

    function automatic ray_pair_t noise_pair();
        ray_pair_t rp;
        rp.v0 = rand_vec();
        rp.v1 = rand_vec();
        rp.v2 = rand_vec();
        rp.orig = rand_vec();
        rp.dir = rand_vec();
        rp.maxd = $urandom;
        return rp;
    endfunction

    function automatic ray_pair_t unit_pair(longint ox, longint oy, longint oz,
                                            longint dx, longint dy, longint dz,
                                            logic [DIST_W-1:0] maxd, bit swap);
        ray_pair_t rp;
        rp.v0 = pack_vec(0, 0, 0);
        rp.v1 = swap ? pack_vec(0, UNIT, 0) : pack_vec(UNIT, 0, 0);
        rp.v2 = swap ? pack_vec(UNIT, 0, 0) : pack_vec(0, UNIT, 0);
        rp.orig = pack_vec(ox, oy, oz);
        rp.dir = pack_vec(dx, dy, dz);
        rp.maxd = maxd;
        return rp;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_hits.push_back(predict_hit(cur_pair, model_eps));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_pairs.size() > 0 && !hold_sender) begin
                    cur_pair <= pending_pairs.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        hit_info_t exp_hit;
        cycle_count <= cycle_count + 1;
        if (cycle_count % 97 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= cycle_count[2];
        endcase
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches <= mismatches + 1;
            end else begin
                exp_hit = expected_hits.pop_front();
                if (m_hit !== exp_hit.hit) begin
                    $error("hit: expected %0d, actual %0d", exp_hit.hit, m_hit);
                    mismatches <= mismatches + 1;
                end
                if (m_distance !== exp_hit.distance) begin
                    $error("distance: expected %h, actual %h", exp_hit.distance, m_distance);
                    mismatches <= mismatches + 1;
                end
                if (m_bary_u !== exp_hit.bary_u) begin
                    $error("bary_u: expected %h, actual %h", exp_hit.bary_u, m_bary_u);
                    mismatches <= mismatches + 1;
                end
                if (m_bary_v !== exp_hit.bary_v) begin
                    $error("bary_v: expected %h, actual %h", exp_hit.bary_v, m_bary_v);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL ray_triangle_intersect_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic drain();
        while (pending_pairs.size() > 0 || s_valid || expected_hits.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] value);
        @(posedge aclk);
        epsilon_wr_en <= 1'b1;
        epsilon_wr_data <= value;
        model_eps = value;
        @(posedge aclk);
        epsilon_wr_en <= 1'b0;
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            pending_pairs.push_back(($urandom_range(0, 9) < 7) ? aimed_pair() : noise_pair());
        end
    endtask

    initial begin
        ray_pair_t rp;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        write_epsilon(EPS_RESET);
        pending_pairs.push_back('0);
        rp = '1;
        pending_pairs.push_back(rp);
        rp.v0 = {3{21'h0F_FFFF}};
        rp.v1 = {3{21'h10_0000}};
        rp.v2 = {21'h10_0000, 21'h0F_FFFF, 21'h10_0000};
        rp.orig = {3{21'h0F_FFFF}};
        rp.dir = {3{21'h10_0000}};
        rp.maxd = 32'hFFFF_FFFF;
        pending_pairs.push_back(rp);
        pending_pairs.push_back(unit_pair(256, 256, -UNIT, 0, 0, UNIT, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(256, 256, -UNIT, 0, 0, UNIT, 32'h0, 0));
        pending_pairs.push_back(unit_pair(256, 256, -UNIT, 0, 0, UNIT, 32'd65536, 0));
        pending_pairs.push_back(unit_pair(256, 256, -UNIT, 0, 0, UNIT, 32'd65537, 0));
        pending_pairs.push_back(unit_pair(256, 256, -UNIT, 0, 0, UNIT, 32'hFFFF_FFFF, 1));
        pending_pairs.push_back(unit_pair(256, 256, -UNIT, 0, 0, -UNIT, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(256, 256, -UNIT, UNIT, 0, 0, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(2048, 256, -UNIT, 0, 0, UNIT, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(0, 256, -UNIT, 0, 0, UNIT, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(768, 768, -UNIT, 0, 0, UNIT, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(256, 256, -UNIT, 0, 0, 1, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(256, 256, -1, 0, 0, UNIT, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(256, 256, -4, 0, 0, 64, 32'hFFFF_FFFF, 0));
        pending_pairs.push_back(unit_pair(300, 200, -UNIT, 3, -5, 700, 32'hFFFF_FFFF, 1));
        drain();

        write_epsilon(16'd0);
        for (int i = 0; i < 4; i++) begin
            pending_pairs.push_back(unit_pair(256, 256, -UNIT, UNIT, 0, 0, 32'hFFFF_FFFF, 0));
            pending_pairs.push_back(unit_pair(256, 256, -1, 0, 0, UNIT, 32'hFFFF_FFFF, 0));
        end
        queue_random(140);
        drain();

        write_epsilon(16'hFFFF);
        queue_random(100);
        drain();

        write_epsilon(16'($urandom_range(0, 2000)));
        queue_random(150);
        drain();

        write_epsilon(EPS_RESET);
        queue_random(70);
        @(posedge aclk);
        hold_sender <= 1'b1;
        while (s_valid || expected_hits.size() > 0) begin
            @(posedge aclk);
        end
        hold_sender <= 1'b0;
        queue_random(80);
        drain();

        if (mismatches == 0) begin
            $display("PASS ray_triangle_intersect_core");
        end else begin
            $display("FAIL ray_triangle_intersect_core");
        end
        $finish;
    end

endmodule
